@@ hdl/lts_pkg.sv @@
// Shared constants and types for the longest target-sum subarray block.
// No dependencies.
`timescale 1ns / 1ps
package lts_pkg;
	localparam int MAX_LEN     = 1024;
	localparam int TABLE_SLOTS = 2048;
	localparam int VALUE_BITS  = 16;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int LEN_W       = 11;
	localparam int SUM_W       = 27;
	localparam int DIFF_W      = 28;
	localparam int TGT_W       = 26;
	localparam int EPOCH_W     = 4;
	localparam int CQ_DEPTH    = 4;
	localparam int CQ_AW       = $clog2(CQ_DEPTH);

	typedef struct packed {
		logic                     ignore;
		logic                     last;
		logic                     ovf;
		logic [LEN_W-1:0]         count;
		logic signed [SUM_W-1:0]  sum;
		logic signed [DIFF_W-1:0] diff;
	} cmd_t;

	typedef struct packed {
		logic [LEN_W-1:0] best;
		logic             is_last;
		logic             ovf;
	} res_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [SUM_W-1:0]   key;
		logic [LEN_W-1:0]   pos;
	} slot_t;
endpackage

@@ hdl/lts_front.sv @@
// Front end: accepts items, keeps count and prefix sum, classifies each item.
// Depends on lts_pkg.
`timescale 1ns / 1ps
module lts_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [lts_pkg::VALUE_BITS-1:0] value,
	input  logic                          last,
	input  logic                          target_sum_we,
	input  logic [lts_pkg::TGT_W-1:0]     target_sum,
	output lts_pkg::cmd_t                 cmd
);
	import lts_pkg::*;

	logic [LEN_W-1:0]         cnt_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     exceeded_q;
	logic signed [TGT_W-1:0]  target_q;
	logic                     at_max;
	logic signed [SUM_W-1:0]  sum_next;

	assign at_max   = (cnt_q == LEN_W'(MAX_LEN));
	assign sum_next = sum_q + {{(SUM_W-VALUE_BITS){value[VALUE_BITS-1]}}, value};

	always_comb begin
		cmd.ignore = at_max;
		cmd.last   = last;
		cmd.ovf    = at_max | exceeded_q;
		cmd.count  = cnt_q + LEN_W'(1);
		cmd.sum    = sum_next;
		cmd.diff   = {sum_next[SUM_W-1], sum_next}
			- {{(DIFF_W-TGT_W){target_q[TGT_W-1]}}, target_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			sum_q      <= '0;
			exceeded_q <= 1'b0;
			target_q   <= '0;
		end else begin
			if (target_sum_we) begin
				target_q <= target_sum;
			end
			if (accept) begin
				if (last) begin
					cnt_q      <= '0;
					sum_q      <= '0;
					exceeded_q <= 1'b0;
				end else if (at_max) begin
					exceeded_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + LEN_W'(1);
					sum_q <= sum_next;
				end
			end
		end
	end
endmodule

@@ hdl/lts_cmd_q.sv @@
// Short item queue between front and back end.
// Depends on lts_pkg.
`timescale 1ns / 1ps
module lts_cmd_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  lts_pkg::cmd_t din,
	input  logic          rd,
	output lts_pkg::cmd_t dout,
	output logic          full,
	output logic          empty
);
	import lts_pkg::*;

	cmd_t             mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wp_q;
	logic [CQ_AW-1:0] rp_q;
	logic [CQ_AW:0]   cnt_q;

	assign full  = (cnt_q == (CQ_AW+1)'(CQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + CQ_AW'(1);
			end
			if (rd) begin
				rp_q <= rp_q + CQ_AW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + (CQ_AW+1)'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - (CQ_AW+1)'(1);
			end
		end
	end
endmodule

@@ hdl/lts_back.sv @@
// Back end: prefix-sum hash table with linear probing, best length, result queue.
// Depends on lts_pkg.
`timescale 1ns / 1ps
module lts_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lts_pkg::cmd_t           cmd,
	input  logic                    cmd_empty,
	output logic                    cmd_pop,
	output logic                    clearing,
	input  logic                    pop,
	output logic                    empty,
	output lts_pkg::res_t           res
);
	import lts_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_DRD   = 7'b0000100,
		S_DCMP  = 7'b0001000,
		S_PRD   = 7'b0010000,
		S_PCMP  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t             state_q;
	cmd_t               cur_q;
	logic [SLOT_W-1:0]  addr_q;
	logic [SLOT_W-1:0]  clr_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [LEN_W-1:0]   best_q;
	slot_t              rd_q;
	slot_t              tbl [TABLE_SLOTS];

	res_t               rq_mem [2];
	logic               rq_wp_q;
	logic               rq_rp_q;
	logic [1:0]         rq_cnt_q;
	logic               rq_push;
	logic               rq_pop;

	logic               mem_we;
	logic [SLOT_W-1:0]  mem_wa;
	slot_t              mem_wd;
	logic               hit_valid;
	logic [LEN_W-1:0]   len;
	logic               diff_fits;

	assign clearing  = (state_q == S_CLEAR);
	assign cmd_pop   = (state_q == S_IDLE) && !cmd_empty && (rq_cnt_q != 2'd2);
	assign hit_valid = (rd_q.epoch == epoch_q);
	assign len       = cur_q.count - rd_q.pos;
	assign diff_fits = (cmd.diff[DIFF_W-1] == cmd.diff[DIFF_W-2]);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = '{epoch: epoch_q, key: cur_q.sum, pos: cur_q.count};
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (state_q == S_PCMP && !hit_valid) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl[mem_wa] <= mem_wd;
		end
		if (state_q == S_DRD || state_q == S_PRD) begin
			rd_q <= tbl[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			epoch_q <= '0;
			best_q  <= '0;
			addr_q  <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(TABLE_SLOTS-1)) begin
						epoch_q <= EPOCH_W'(1);
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_pop) begin
						cur_q <= cmd;
						if (cmd.ignore) begin
							state_q <= S_DONE;
						end else if (cmd.diff == '0) begin
							if (cmd.count > best_q) begin
								best_q <= cmd.count;
							end
							addr_q  <= cmd.sum[SLOT_W-1:0];
							state_q <= (cmd.sum == '0) ? S_DONE : S_PRD;
						end else if (diff_fits) begin
							addr_q  <= cmd.diff[SLOT_W-1:0];
							state_q <= S_DRD;
						end else begin
							addr_q  <= cmd.sum[SLOT_W-1:0];
							state_q <= (cmd.sum == '0) ? S_DONE : S_PRD;
						end
					end
				end
				S_DRD: begin
					state_q <= S_DCMP;
				end
				S_DCMP: begin
					if (hit_valid && rd_q.key != cur_q.diff[SUM_W-1:0]) begin
						addr_q  <= addr_q + SLOT_W'(1);
						state_q <= S_DRD;
					end else begin
						if (hit_valid && len > best_q) begin
							best_q <= len;
						end
						addr_q  <= cur_q.sum[SLOT_W-1:0];
						state_q <= (cur_q.sum == '0) ? S_DONE : S_PRD;
					end
				end
				S_PRD: begin
					state_q <= S_PCMP;
				end
				S_PCMP: begin
					if (hit_valid && rd_q.key != cur_q.sum) begin
						addr_q  <= addr_q + SLOT_W'(1);
						state_q <= S_PRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cur_q.last) begin
						best_q <= '0;
						if (epoch_q == '1) begin
							clr_q   <= '0;
							state_q <= S_CLEAR;
						end else begin
							epoch_q <= epoch_q + EPOCH_W'(1);
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	assign rq_push = (state_q == S_DONE);
	assign rq_pop  = pop && (rq_cnt_q != 2'd0);
	assign empty   = (rq_cnt_q == 2'd0);
	assign res     = rq_mem[rq_rp_q];

	always_ff @(posedge clk) begin
		if (rq_push) begin
			rq_mem[rq_wp_q] <= '{best: best_q, is_last: cur_q.last, ovf: cur_q.ovf};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wp_q  <= 1'b0;
			rq_rp_q  <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			if (rq_push) begin
				rq_wp_q <= ~rq_wp_q;
			end
			if (rq_pop) begin
				rq_rp_q <= ~rq_rp_q;
			end
			if (rq_push && !rq_pop) begin
				rq_cnt_q <= rq_cnt_q + 2'd1;
			end else if (rq_pop && !rq_push) begin
				rq_cnt_q <= rq_cnt_q - 2'd1;
			end
		end
	end
endmodule

@@ hdl/longest_target_sum_subarray_prefix.sv @@
// The back end takes one item at a time: an ignored item or one with no table probe goes
// straight to its result, a probe reads and then compares a table slot, and each extra linear
// probe repeats that read and compare. A new item is taken once the last is done and results have room.
// Reset: asynchronous, then a table clearing pass over all 2048 slots with full high;
// the same pass runs after every 15th array ends.
// Top level: front end, item queue, back end. Depends on lts_pkg and the lts_ modules.
`timescale 1ns / 1ps
module longest_target_sum_subarray_prefix (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [lts_pkg::VALUE_BITS-1:0] value,
	input  logic                           last,
	input  logic                           pop,
	output logic                           empty,
	output logic [lts_pkg::LEN_W-1:0]      best_length,
	output logic                           is_last,
	output logic                           overflow,
	input  logic                           target_sum_we,
	input  logic [lts_pkg::TGT_W-1:0]      target_sum
);
	import lts_pkg::*;

	cmd_t cmd_in;
	cmd_t cmd_out;
	res_t res;
	logic cq_full;
	logic cq_empty;
	logic cq_pop;
	logic clearing;
	logic accept;

	assign full   = cq_full | clearing;
	assign accept = push & ~full;

	lts_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .value(value), .last(last),
		.target_sum_we(target_sum_we), .target_sum(target_sum), .cmd(cmd_in)
	);

	lts_cmd_q u_cq (
		.clk(clk), .arst_n(arst_n), .wr(accept), .din(cmd_in), .rd(cq_pop),
		.dout(cmd_out), .full(cq_full), .empty(cq_empty)
	);

	lts_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_out), .cmd_empty(cq_empty),
		.cmd_pop(cq_pop), .clearing(clearing), .pop(pop), .empty(empty), .res(res)
	);

	assign best_length = res.best;
	assign is_last     = res.is_last;
	assign overflow    = res.ovf;
endmodule

@@ hdl/lts_checker.sv @@
// Port-level checks on the top level, attached by bind.
// Depends on lts_pkg and longest_target_sum_subarray_prefix.
`timescale 1ns / 1ps
module lts_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           pop,
	input logic                           empty,
	input logic [lts_pkg::LEN_W-1:0]      best_length,
	input logic                           is_last,
	input logic                           overflow
);
	import lts_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(best_length))
		else $error("item changed while waiting");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> best_length <= LEN_W'(MAX_LEN))
		else $error("best length out of range");

	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !is_last |=> empty || best_length >= $past(best_length))
		else $error("best length shrank within an array");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !is_last && overflow |=> empty || overflow)
		else $error("overflow dropped within an array");
endmodule

bind longest_target_sum_subarray_prefix lts_checker u_lts_checker (.*);

@@ tb/longest_target_sum_subarray_prefix_test.sv @@
// Testbench for longest_target_sum_subarray_prefix: drives arrays of signed elements
// through the push/full queue and checks every popped item against an in-bench
// prefix-sum table model. Depends on lts_pkg and the block RTL.
`timescale 1ns / 1ps
module longest_target_sum_subarray_prefix_test;
	import lts_pkg::*;

	localparam int WATCH_LIMIT = 20000;

	typedef struct {
		logic [LEN_W-1:0] best;
		logic             is_last;
		logic             ovf;
	} length_item_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    push = 1'b0;
	logic [VALUE_BITS-1:0]   value = '0;
	logic                    last = 1'b0;
	logic                    pop = 1'b0;
	logic                    target_sum_we = 1'b0;
	logic [TGT_W-1:0]        target_sum = '0;
	logic                    full, empty, is_last, overflow;
	logic [LEN_W-1:0]        best_length;

	// predictor state
	longint                  first_pos[longint];
	longint                  run_sum;
	int                      elem_count;
	int                      longest;
	bit                      exceeded;
	longint                  tgt;

	length_item_t            expected_lengths[$];
	int                      mismatches = 0;
	int                      watch = 0;
	int                      idle_pct = 38;
	bit                      done = 1'b0;

	longest_target_sum_subarray_prefix u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .value(value),
		.last(last), .pop(pop), .empty(empty), .best_length(best_length),
		.is_last(is_last), .overflow(overflow),
		.target_sum_we(target_sum_we), .target_sum(target_sum)
	);

	always #5 clk = ~clk;

	function automatic void clear_array();
		first_pos.delete();
		run_sum = 0;
		elem_count = 0;
		longest = 0;
		exceeded = 1'b0;
	endfunction

	function automatic void predict_length(logic [VALUE_BITS-1:0] v, bit lst);
		length_item_t e;
		longint key;
		if (elem_count >= MAX_LEN) begin
			exceeded = 1'b1;
		end else begin
			elem_count++;
			run_sum += longint'($signed(v));
			key = run_sum - tgt;
			if (key == 0) begin
				if (elem_count > longest) longest = elem_count;
			end else if (first_pos.exists(key)) begin
				if (elem_count - first_pos[key] > longest)
					longest = elem_count - int'(first_pos[key]);
			end
			if (run_sum != 0 && !first_pos.exists(run_sum))
				first_pos[run_sum] = elem_count;
		end
		e.best = longest[LEN_W-1:0];
		e.is_last = lst;
		e.ovf = exceeded;
		expected_lengths.push_back(e);
		if (lst) clear_array();
	endfunction

	task automatic send_item(logic [VALUE_BITS-1:0] v, bit lst);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		value <= v;
		last <= lst;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_length(v, lst);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_lengths.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_target(longint t);
		drain();
		target_sum_we <= 1'b1;
		target_sum <= t[TGT_W-1:0];
		@(posedge clk);
		target_sum_we <= 1'b0;
		tgt = t;
	endtask

	task automatic send_array(int len, int lo, int hi);
		for (int i = 0; i < len; i++)
			send_item(VALUE_BITS'($urandom_range(hi - lo) + lo), i == len - 1);
	endtask

	task automatic test_directed();
		set_target(0);
		send_item(16'h7fff, 1'b0);
		send_item(16'h8001, 1'b0);
		send_item(16'h0000, 1'b0);
		send_item(16'h8000, 1'b0);
		send_item(16'h8000, 1'b1);
		send_item(16'h0000, 1'b1);
		set_target(3);
		send_item(16'd1, 1'b0);
		send_item(16'd2, 1'b0);
		send_item(16'hffff, 1'b0);
		send_item(16'd1, 1'b0);
		send_item(16'd3, 1'b1);
		set_target(-33554432);
		send_item(16'h8000, 1'b0);
		send_item(16'h8000, 1'b1);
		set_target(33554431);
		send_item(16'h7fff, 1'b0);
		send_item(16'h7fff, 1'b1);
	endtask

	task automatic test_overflow();
		set_target(2);
		idle_pct = 0;
		// long array pushed past the maximum length, ending on an ignored element
		for (int i = 0; i < MAX_LEN + 3; i++)
			send_item(VALUE_BITS'($urandom_range(4) - 2), i == MAX_LEN + 2);
		idle_pct = 38;
	endtask

	task automatic test_random();
		int n;
		int len;
		n = 0;
		while (n < 650) begin
			if ($urandom_range(9) == 0) set_target(longint'($urandom_range(8)) - 4);
			len = $urandom_range(40, 1);
			if ($urandom_range(3) == 0)
				send_array(len, -32768, 32767);
			else
				send_array(len, -3, 3);
			n += len;
			if (n > 300 && n < 340) drain();
		end
		set_target(-7);
	endtask

	always @(posedge clk) begin
		length_item_t e;
		if (arst_n && pop && !empty) begin
			if (expected_lengths.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item best=%0d", best_length);
			end else begin
				e = expected_lengths.pop_front();
				if (best_length !== e.best || is_last !== e.is_last || overflow !== e.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp best=%0d last=%0d ovf=%0d got %0d %0d %0d",
							e.best, e.is_last, e.ovf, best_length, is_last, overflow);
				end
			end
		end
		pop <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n || done) watch <= 0;
		else watch <= watch + 1;
		if (watch > WATCH_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		clear_array();
		tgt = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_overflow();
		test_random();
		drain();
		done = 1'b1;
		if (mismatches == 0 && expected_lengths.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
